// ===== rtl/core/tbbc_pkg.sv =====
// Shared types, codes and helpers for the tokenized byte classifier.
`default_nettype none

package tbbc_pkg;

  localparam int DataW  = 8;
  localparam int ValueW = 16;
  localparam int KindW  = 3;
  localparam int StatW  = 2;
  localparam int OutW   = 24;  // kind, value, new_run, status padded to bytes

  localparam logic [7:0] ByteCr      = 8'h0D;
  localparam logic [7:0] ByteEnd     = 8'hFF;
  localparam logic [7:0] ByteLineRef = 8'h8D;
  localparam logic [7:0] ByteRem     = 8'hF4;
  localparam logic [7:0] ByteQuote   = 8'h22;
  localparam logic [7:0] ByteAmp     = 8'h26;
  localparam logic [7:0] ByteDot     = 8'h2E;
  localparam logic [7:0] RefKey      = 8'h54;
  localparam logic [7:0] RefLowMask  = 8'h3F;
  localparam logic [7:0] RefHighMask = 8'hC0;
  localparam logic [7:0] TokenMin    = 8'h80;
  localparam logic [7:0] MinLen      = 8'd4;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_HIGH  = 7'b0000010,
    PH_LOW   = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_BODY  = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_ERROR = 7'b1000000
  } phase_t;

  typedef enum logic [KindW-1:0] {
    K_HEADER = 3'd0,
    K_LINE   = 3'd1,
    K_NUMBER = 3'd2,
    K_STRING = 3'd3,
    K_TOKEN  = 3'd4,
    K_REM    = 3'd5,
    K_CHAR   = 3'd6,
    K_HELD   = 3'd7
  } kind_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RC_IDLE  = 2'd0,
    RC_BYTE0 = 2'd1,
    RC_BYTE1 = 2'd2,
    RC_BYTE2 = 2'd3
  } refcnt_t;

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hexlet(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h46);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return digit_char(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == 8'h5F) || (c == 8'h25) || (c == 8'h24);
  endfunction

  // Rebuild a packed line reference from its three stored bytes.
  function automatic logic [ValueW-1:0] unpack_ref(input logic [7:0] b0,
                                                   input logic [7:0] b1,
                                                   input logic [7:0] b2);
    logic [7:0] k;
    logic [7:0] lo;
    logic [7:0] hi;
    k  = b0 ^ RefKey;
    lo = (b1 & RefLowMask) | ({k[5:0], 2'b00} & RefHighMask);
    hi = (b2 & RefLowMask) | ({k[3:0], 4'b0000} & RefHighMask);
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tokenized_basic_byte_classifier_unit.sv =====
// Top level: byte-at-a-time classifier for tokenized line-numbered programs.
// The result of an accepted input item is computed combinationally and loaded into the output register.
// Throughput: one item per cycle; the parser state and the output register both advance
//   on every accepted item, and the output register alone sets the pace under backpressure.
// Reset: rst (synchronous, active high) clears the parser state and drops the output item.
// An input item with first_byte set restarts the parser before that byte is classified.
`default_nettype none

module tokenized_basic_byte_classifier_unit
  import tbbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [DataW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire logic                s_axis_tuser,   // [0] first_byte
  input  wire logic                s_axis_tlast,   // last_byte
  // result stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutW-1:0]     m_axis_tdata,   // [2:0] kind, [18:3] value,
                                                   // [19] new_run, [21:20] status, [23:22] 0
  output      logic                m_axis_tlast    // line_end
);

  // Parser state registers
  phase_t             phase;
  logic [7:0]         line_high;
  logic [7:0]         bytes_left;
  logic               in_str;
  logic               in_rem;
  logic [7:0]         prev_char;
  kind_t              last_class;
  refcnt_t            ref_count;
  logic [7:0]         ref_b0;
  logic [7:0]         ref_b1;

  phase_t             phase_next;
  logic [7:0]         line_high_next;
  logic [7:0]         bytes_left_next;
  logic               in_str_next;
  logic               in_rem_next;
  logic [7:0]         prev_char_next;
  kind_t              last_class_next;
  refcnt_t            ref_count_next;
  logic [7:0]         ref_b0_next;
  logic [7:0]         ref_b1_next;

  // State as seen by this item: a first_byte item sees the reset values
  phase_t             e_phase;
  logic [7:0]         e_line_high;
  logic [7:0]         e_bytes_left;
  logic               e_in_str;
  logic               e_in_rem;
  logic [7:0]         e_prev_char;
  kind_t              e_last_class;
  refcnt_t            e_ref_count;
  logic [7:0]         e_ref_b0;
  logic [7:0]         e_ref_b1;

  // Result of this item
  kind_t              r_kind;
  logic [ValueW-1:0]  r_value;
  logic               r_nrun;
  logic               r_lend;
  status_t            r_status;

  // Output register
  kind_t              o_kind;
  logic [ValueW-1:0]  o_value;
  logic               o_nrun;
  logic               o_lend;
  status_t            o_status;
  logic               o_valid;

  logic               accept;
  logic [7:0]         c;
  kind_t              cls;
  logic               judge;
  logic [7:0]         bl_dec;

  assign c      = s_axis_tdata;
  assign bl_dec = e_bytes_left - 8'd1;

  // Take a new item whenever the output register is empty or being emptied.
  assign s_axis_tready = !o_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tuser) begin
      e_phase      = PH_START;
      e_line_high  = '0;
      e_bytes_left = '0;
      e_in_str     = 1'b0;
      e_in_rem     = 1'b0;
      e_prev_char  = '0;
      e_last_class = K_HEADER;
      e_ref_count  = RC_IDLE;
      e_ref_b0     = '0;
      e_ref_b1     = '0;
    end else begin
      e_phase      = phase;
      e_line_high  = line_high;
      e_bytes_left = bytes_left;
      e_in_str     = in_str;
      e_in_rem     = in_rem;
      e_prev_char  = prev_char;
      e_last_class = last_class;
      e_ref_count  = ref_count;
      e_ref_b0     = ref_b0;
      e_ref_b1     = ref_b1;
    end
  end

  always_comb begin
    phase_next      = e_phase;
    line_high_next  = e_line_high;
    bytes_left_next = e_bytes_left;
    in_str_next     = e_in_str;
    in_rem_next     = e_in_rem;
    prev_char_next  = e_prev_char;
    last_class_next = e_last_class;
    ref_count_next  = e_ref_count;
    ref_b0_next     = e_ref_b0;
    ref_b1_next     = e_ref_b1;

    r_kind   = K_HEADER;
    r_value  = {8'h00, c};
    r_nrun   = 1'b0;
    r_lend   = 1'b0;
    r_status = ST_OK;
    cls      = K_HEADER;
    judge    = 1'b0;

    unique case (e_phase)
      PH_START: begin
        if (c == ByteCr) begin
          phase_next      = PH_HIGH;
          in_str_next     = 1'b0;
          in_rem_next     = 1'b0;
          prev_char_next  = '0;
          last_class_next = K_HEADER;
          ref_count_next  = RC_IDLE;
        end else begin
          phase_next = PH_ERROR;
          r_status   = ST_BAD;
        end
      end
      PH_HIGH: begin
        if (c == ByteEnd) begin
          phase_next = PH_DONE;
          r_status   = ST_END;
        end else begin
          line_high_next = c;
          phase_next     = PH_LOW;
        end
      end
      PH_LOW: begin
        r_kind     = K_LINE;
        r_value    = {e_line_high, c};
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (c < MinLen) begin
          phase_next = PH_ERROR;
          r_status   = ST_BAD;
        end else begin
          bytes_left_next = c - MinLen;
          if (c == MinLen) begin
            r_lend     = 1'b1;
            phase_next = PH_START;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        judge = 1'b1;
        if (e_ref_count != RC_IDLE) begin
          // Held line reference bytes take no part in run tracking.
          judge = 1'b0;
          if (e_ref_count == RC_BYTE2) begin
            r_kind         = K_NUMBER;
            r_value        = unpack_ref(e_ref_b0, e_ref_b1, c);
            ref_count_next = RC_IDLE;
          end else begin
            r_kind = K_HELD;
            if (e_ref_count == RC_BYTE0) begin
              ref_b0_next    = c;
              ref_count_next = RC_BYTE1;
            end else begin
              ref_b1_next    = c;
              ref_count_next = RC_BYTE2;
            end
          end
        end else if (e_in_rem) begin
          cls    = K_REM;
          r_kind = K_REM;
        end else if (e_in_str) begin
          cls    = K_STRING;
          r_kind = K_STRING;
          if (c == ByteQuote) begin
            in_str_next = 1'b0;
          end
          prev_char_next = c;
        end else if (c == ByteLineRef) begin
          // Open a line reference only if its three bytes fit in the record.
          if (e_bytes_left >= MinLen) begin
            cls            = K_NUMBER;
            r_kind         = K_HELD;
            ref_count_next = RC_BYTE0;
          end else begin
            cls    = K_TOKEN;
            r_kind = K_TOKEN;
          end
          prev_char_next = '0;
        end else if (c >= TokenMin) begin
          cls    = K_TOKEN;
          r_kind = K_TOKEN;
          if (c == ByteRem) begin
            in_rem_next = 1'b1;
          end
          prev_char_next = '0;
        end else if (c == ByteQuote) begin
          cls            = K_STRING;
          r_kind         = K_STRING;
          in_str_next    = 1'b1;
          prev_char_next = c;
        end else begin
          // An ampersand, or a digit that does not continue a name, starts a number;
          // digits, hex digits and a point continue a number.
          if ((c == ByteAmp) || (digit_char(c) && !is_ident(e_prev_char))) begin
            cls = K_NUMBER;
          end else if ((e_last_class == K_NUMBER) &&
                       (digit_char(c) || is_hexlet(c) || (c == ByteDot))) begin
            cls = K_NUMBER;
          end else begin
            cls = K_CHAR;
          end
          r_kind         = cls;
          prev_char_next = c;
        end
        if (judge) begin
          r_nrun          = (cls != e_last_class);
          last_class_next = cls;
        end
        bytes_left_next = bl_dec;
        if (bl_dec == 8'd0) begin
          r_lend     = 1'b1;
          phase_next = PH_START;
        end
      end
      PH_DONE: begin
        r_status = ST_END;
      end
      default: begin
        phase_next = PH_ERROR;
        r_status   = ST_BAD;
      end
    endcase

    // Flag data that stops inside a record.
    if (s_axis_tlast && (r_status == ST_OK) &&
        ((phase_next == PH_HIGH) || (phase_next == PH_LOW) ||
         (phase_next == PH_LEN) || (phase_next == PH_BODY))) begin
      r_status = ST_TRUNC;
    end
  end

  // Advance parser state on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      line_high  <= '0;
      bytes_left <= '0;
      in_str     <= 1'b0;
      in_rem     <= 1'b0;
      prev_char  <= '0;
      last_class <= K_HEADER;
      ref_count  <= RC_IDLE;
      ref_b0     <= '0;
      ref_b1     <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      line_high  <= line_high_next;
      bytes_left <= bytes_left_next;
      in_str     <= in_str_next;
      in_rem     <= in_rem_next;
      prev_char  <= prev_char_next;
      last_class <= last_class_next;
      ref_count  <= ref_count_next;
      ref_b0     <= ref_b0_next;
      ref_b1     <= ref_b1_next;
    end
  end

  // Output register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (accept) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_kind   <= r_kind;
      o_value  <= r_value;
      o_nrun   <= r_nrun;
      o_lend   <= r_lend;
      o_status <= r_status;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {2'b00, o_status, o_nrun, o_value, o_kind};
  assign m_axis_tlast  = o_lend;

endmodule

`default_nettype wire

// ===== rtl/core/tbbc_checker.sv =====
// Port-level checker for the tokenized byte classifier, bound to the top level.
`default_nettype none

module tbbc_checker
  import tbbc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [DataW-1:0]  s_axis_tdata,
  input wire logic              s_axis_tuser,
  input wire logic              s_axis_tlast,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OutW-1:0]   m_axis_tdata,
  input wire logic              m_axis_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An offered input item carries known bits.
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid |-> !$isunknown({s_axis_tdata, s_axis_tuser, s_axis_tlast}))
    else $error("offered item has unknown bits");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // A record end is always reported with an ok status.
  a_lend_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[21:20] == ST_OK)
    else $error("line end with non-ok status");

  // An accepted item shows up as a result in the next cycle.
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

endmodule

bind tokenized_basic_byte_classifier_unit tbbc_checker u_tbbc_checker (.*);

`default_nettype wire
